[rtl/dcdw_pkg.sv]
// Shared types, codes and constants for the drive command decoder with watchdog.
package dcdw_pkg;

   localparam int CURVE_DIVISOR_DEFAULT     = 4;
   localparam int TICK_COUNTER_BITS_DEFAULT = 16;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_PROFILE_SELECT   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INACTIVITY_LIMIT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CURVE_MIN_SPEED  = 2'd2;

   localparam logic        PROFILE_SIMPLE  = 1'b0;
   localparam logic        PROFILE_APP     = 1'b1;
   localparam logic        PROFILE_RESET   = PROFILE_APP;
   localparam logic [15:0] LIMIT_RESET     = 16'd350;
   localparam logic [7:0]  CURVE_MIN_RESET = 8'd80;

   localparam logic [7:0] SPEED_RESET = 8'd120;
   localparam logic [7:0] SPEED_100   = 8'd100;
   localparam logic [7:0] SPEED_120   = 8'd120;
   localparam logic [7:0] SPEED_140   = 8'd140;
   localparam logic [7:0] SPEED_160   = 8'd160;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_1   = 8'h31;
   localparam logic [7:0] CH_2   = 8'h32;
   localparam logic [7:0] CH_3   = 8'h33;
   localparam logic [7:0] CH_4   = 8'h34;
   localparam logic [7:0] CH_B   = 8'h42;
   localparam logic [7:0] CH_C   = 8'h43;
   localparam logic [7:0] CH_D   = 8'h44;
   localparam logic [7:0] CH_E   = 8'h45;
   localparam logic [7:0] CH_F   = 8'h46;
   localparam logic [7:0] CH_G   = 8'h47;
   localparam logic [7:0] CH_H   = 8'h48;
   localparam logic [7:0] CH_I   = 8'h49;
   localparam logic [7:0] CH_J   = 8'h4A;
   localparam logic [7:0] CH_K   = 8'h4B;
   localparam logic [7:0] CH_L   = 8'h4C;
   localparam logic [7:0] CH_N   = 8'h4E;
   localparam logic [7:0] CH_R   = 8'h52;
   localparam logic [7:0] CH_S   = 8'h53;
   localparam logic [7:0] CH_U   = 8'h55;
   localparam logic [7:0] CH_X   = 8'h58;
   localparam logic [7:0] CH_Y   = 8'h59;
   localparam logic [7:0] CH_LU  = 8'h75;

   typedef enum logic [2:0] {
      ST_NONE = 3'd0,
      ST_DONE = 3'd1,
      ST_BAD  = 3'd2,
      ST_LINE = 3'd3,
      ST_WDOG = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      DIR_OFF = 2'd0,
      DIR_FWD = 2'd1,
      DIR_REV = 2'd2
   } dir_type;

   typedef struct packed {
      logic        profile;
      logic [15:0] limit;
      logic [7:0]  curve_min;
   } cfg_type;

   typedef struct packed {
      logic [7:0] speed;
      dir_type    right_dir;
      logic [7:0] right_duty;
      dir_type    left_dir;
      logic [7:0] left_duty;
      logic       radio_open;
      logic       wired_open;
      logic       armed;
   } state_type;

   typedef struct packed {
      status_type status;
      dir_type    right_dir;
      logic [7:0] right_speed;
      dir_type    left_dir;
      logic [7:0] left_speed;
      logic [7:0] speed_level;
      logic       armed;
   } result_type;

   function automatic logic is_quick(input logic [7:0] c);
      logic hit;
      begin
         hit = (c == CH_1) || (c == CH_2) || (c == CH_3) || (c == CH_4) ||
               (c == CH_F) || (c == CH_B) || (c == CH_U) || (c == CH_LU) ||
               (c == CH_N) || (c == CH_L) || (c == CH_R) || (c == CH_X) ||
               (c == CH_G) || (c == CH_H) || (c == CH_D) || (c == CH_E) ||
               (c == CH_C) || (c == CH_I) || (c == CH_J) || (c == CH_K) ||
               (c == CH_S) || (c == CH_Y);
         return hit;
      end
   endfunction

endpackage

[rtl/drive_command_decoder_watchdog_top.sv]
// Drive command decoder with radio inactivity watchdog: top level.
// A transaction's result is registered in the result queue when it is accepted and offered from its head.
// Throughput: one transaction per cycle; under stall a two-entry queue takes them until full.
// Reset (synchronous, active high) restores the registers, motors off, speed 120, queue empty.
module drive_command_decoder_watchdog_top #(
   parameter int CURVE_DIVISOR     = dcdw_pkg::CURVE_DIVISOR_DEFAULT,
   parameter int TICK_COUNTER_BITS = dcdw_pkg::TICK_COUNTER_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_operation,
   input  logic [7:0]                       req_data_byte,
   input  logic                             req_from_radio,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [2:0]                       rsp_status,
   output logic [1:0]                       rsp_right_direction,
   output logic [7:0]                       rsp_right_speed,
   output logic [1:0]                       rsp_left_direction,
   output logic [7:0]                       rsp_left_speed,
   output logic [7:0]                       rsp_speed_level,
   output logic                             rsp_watchdog_armed,
   input  logic                             csr_write_enable,
   input  logic [dcdw_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [dcdw_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import dcdw_pkg::*;

   localparam int RESULT_W = $bits(result_type);

   cfg_type                      cfg_ff, cfg_in;
   state_type                    state_ff, state_in, state_dec;
   logic [TICK_COUNTER_BITS-1:0] idle_ff, idle_in, idle_dec;
   status_type                   status_dec;
   result_type                   result_push, result_head;
   logic                         req_accept;
   logic                         rsp_accept;
   logic                         fifo_full;
   logic [RESULT_W-1:0]          head_bits;

   assign req_stall  = fifo_full;
   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid && !rsp_stall;

   dcdw_decode #(
      .CURVE_DIVISOR     (CURVE_DIVISOR),
      .TICK_COUNTER_BITS (TICK_COUNTER_BITS)
   ) u_decode (
      .cfg        (cfg_ff),
      .state_cur  (state_ff),
      .idle_cur   (idle_ff),
      .operation  (req_operation),
      .data_byte  (req_data_byte),
      .from_radio (req_from_radio),
      .state_nxt  (state_dec),
      .idle_nxt   (idle_dec),
      .status     (status_dec)
   );

   always_comb begin
      cfg_in   = cfg_ff;
      state_in = state_ff;
      idle_in  = idle_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_PROFILE_SELECT: begin
               cfg_in.profile = csr_write_data[0];
               state_in.speed = SPEED_RESET;
            end
            CSR_INACTIVITY_LIMIT: cfg_in.limit     = csr_write_data;
            CSR_CURVE_MIN_SPEED:  cfg_in.curve_min = csr_write_data[7:0];
            default: ;
         endcase
      end else if (req_accept) begin
         state_in = state_dec;
         idle_in  = idle_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.profile    <= PROFILE_RESET;
         cfg_ff.limit      <= LIMIT_RESET;
         cfg_ff.curve_min  <= CURVE_MIN_RESET;
         state_ff.speed      <= SPEED_RESET;
         state_ff.right_dir  <= DIR_OFF;
         state_ff.right_duty <= 8'd0;
         state_ff.left_dir   <= DIR_OFF;
         state_ff.left_duty  <= 8'd0;
         state_ff.radio_open <= 1'b0;
         state_ff.wired_open <= 1'b0;
         state_ff.armed      <= 1'b0;
         idle_ff             <= '0;
      end else begin
         cfg_ff   <= cfg_in;
         state_ff <= state_in;
         idle_ff  <= idle_in;
      end
   end

   always_comb begin
      result_push.status      = status_dec;
      result_push.right_dir   = state_dec.right_dir;
      result_push.right_speed = state_dec.right_duty;
      result_push.left_dir    = state_dec.left_dir;
      result_push.left_speed  = state_dec.left_duty;
      result_push.speed_level = state_dec.speed;
      result_push.armed       = state_dec.armed;
   end

   dcdw_out_fifo #(
      .WIDTH (RESULT_W)
   ) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_data (result_push),
      .pop       (rsp_accept),
      .not_empty (rsp_valid),
      .full      (fifo_full),
      .head_data (head_bits)
   );

   assign result_head         = result_type'(head_bits);
   assign rsp_status          = result_head.status;
   assign rsp_right_direction = result_head.right_dir;
   assign rsp_right_speed     = result_head.right_speed;
   assign rsp_left_direction  = result_head.left_dir;
   assign rsp_left_speed      = result_head.left_speed;
   assign rsp_speed_level     = result_head.speed_level;
   assign rsp_watchdog_armed  = result_head.armed;

`ifndef NO_ASSERTIONS
   a_stall_only_when_backed_up: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stalled with no result pending");

   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid)
      else $error("accepted transaction produced no result");

   a_disarmed_counter_clear: assert property (@(posedge clock)
      !state_ff.armed |-> idle_ff == '0)
      else $error("idle counter running while watchdog disarmed");

   a_watchdog_stop_motors_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_WDOG |->
         rsp_right_direction == DIR_OFF && rsp_left_direction == DIR_OFF &&
         !rsp_watchdog_armed)
      else $error("watchdog stop left a motor running");
`endif

endmodule

[rtl/dcdw_decode.sv]
// Next-state and status logic for one byte or tick transaction.
module dcdw_decode #(
   parameter int CURVE_DIVISOR     = dcdw_pkg::CURVE_DIVISOR_DEFAULT,
   parameter int TICK_COUNTER_BITS = dcdw_pkg::TICK_COUNTER_BITS_DEFAULT
) (
   input  dcdw_pkg::cfg_type          cfg,
   input  dcdw_pkg::state_type        state_cur,
   input  logic [TICK_COUNTER_BITS-1:0] idle_cur,
   input  logic                       operation,
   input  logic [7:0]                 data_byte,
   input  logic                       from_radio,
   output dcdw_pkg::state_type        state_nxt,
   output logic [TICK_COUNTER_BITS-1:0] idle_nxt,
   output dcdw_pkg::status_type       status
);
   import dcdw_pkg::*;

   localparam int RECIP_SHIFT = 16;
   localparam logic [RECIP_SHIFT:0] RECIP =
      (RECIP_SHIFT+1)'(((1 << RECIP_SHIFT) + CURVE_DIVISOR - 1) / CURVE_DIVISOR);
   localparam int CMP_W = (TICK_COUNTER_BITS > 16) ? TICK_COUNTER_BITS : 16;

   typedef enum logic [1:0] {
      ACT_NONE,
      ACT_MOVE,
      ACT_STOP,
      ACT_BAD
   } act_type;

   logic [RECIP_SHIFT+8:0]       product;
   logic [7:0]                   quotient;
   logic [7:0]                   raised;
   logic [7:0]                   inner;
   logic [TICK_COUNTER_BITS-1:0] idle_sat;
   logic                         limit_hit;
   logic                         line_open;
   act_type                      act;

   // speed / CURVE_DIVISOR, exact for 8-bit speeds
   assign product  = (RECIP_SHIFT+9)'(state_cur.speed) * (RECIP_SHIFT+9)'(RECIP);
   assign quotient = product[RECIP_SHIFT+7:RECIP_SHIFT];
   assign raised   = (quotient < cfg.curve_min) ? cfg.curve_min : quotient;
   assign inner    = (quotient == 8'd0) ? 8'd0 :
                     ((raised > state_cur.speed) ? state_cur.speed : raised);

   assign idle_sat  = (idle_cur == '1) ? idle_cur : TICK_COUNTER_BITS'(idle_cur + 1'b1);
   assign limit_hit = CMP_W'(idle_sat) >= CMP_W'(cfg.limit);
   assign line_open = from_radio ? state_cur.radio_open : state_cur.wired_open;

   always_comb begin
      state_nxt = state_cur;
      idle_nxt  = idle_cur;
      status    = ST_NONE;
      act       = ACT_NONE;
      if (operation == OP_TICK) begin
         if (state_cur.armed) begin
            if (limit_hit) begin
               state_nxt.right_dir  = DIR_OFF;
               state_nxt.right_duty = 8'd0;
               state_nxt.left_dir   = DIR_OFF;
               state_nxt.left_duty  = 8'd0;
               state_nxt.armed      = 1'b0;
               idle_nxt             = '0;
               status               = ST_WDOG;
            end else begin
               idle_nxt = idle_sat;
            end
         end
      end else if (data_byte == CH_CR) begin
         status = ST_NONE;
      end else if (!line_open && is_quick(data_byte)) begin
         if (cfg.profile == PROFILE_APP) begin
            unique case (data_byte)
               CH_1: state_nxt.speed = SPEED_100;
               CH_2: state_nxt.speed = SPEED_120;
               CH_3: state_nxt.speed = SPEED_140;
               CH_4: state_nxt.speed = SPEED_160;
               CH_F: begin
                  state_nxt.right_dir = DIR_FWD; state_nxt.right_duty = state_cur.speed;
                  state_nxt.left_dir  = DIR_FWD; state_nxt.left_duty  = state_cur.speed;
                  act = ACT_MOVE;
               end
               CH_B: begin
                  state_nxt.right_dir = DIR_REV; state_nxt.right_duty = state_cur.speed;
                  state_nxt.left_dir  = DIR_REV; state_nxt.left_duty  = state_cur.speed;
                  act = ACT_MOVE;
               end
               CH_L: begin
                  state_nxt.right_dir = DIR_FWD; state_nxt.right_duty = state_cur.speed;
                  state_nxt.left_dir  = DIR_REV; state_nxt.left_duty  = state_cur.speed;
                  act = ACT_MOVE;
               end
               CH_R: begin
                  state_nxt.right_dir = DIR_REV; state_nxt.right_duty = state_cur.speed;
                  state_nxt.left_dir  = DIR_FWD; state_nxt.left_duty  = state_cur.speed;
                  act = ACT_MOVE;
               end
               CH_G: begin
                  state_nxt.right_dir = DIR_FWD; state_nxt.right_duty = state_cur.speed;
                  state_nxt.left_dir  = DIR_FWD; state_nxt.left_duty  = inner;
                  act = ACT_MOVE;
               end
               CH_H: begin
                  state_nxt.right_dir = DIR_FWD; state_nxt.right_duty = inner;
                  state_nxt.left_dir  = DIR_FWD; state_nxt.left_duty  = state_cur.speed;
                  act = ACT_MOVE;
               end
               CH_I: begin
                  state_nxt.right_dir = DIR_REV; state_nxt.right_duty = state_cur.speed;
                  state_nxt.left_dir  = DIR_REV; state_nxt.left_duty  = inner;
                  act = ACT_MOVE;
               end
               CH_J: begin
                  state_nxt.right_dir = DIR_REV; state_nxt.right_duty = inner;
                  state_nxt.left_dir  = DIR_REV; state_nxt.left_duty  = state_cur.speed;
                  act = ACT_MOVE;
               end
               CH_S: begin
                  state_nxt.right_dir = DIR_OFF; state_nxt.right_duty = 8'd0;
                  state_nxt.left_dir  = DIR_OFF; state_nxt.left_duty  = 8'd0;
                  act = ACT_STOP;
               end
               CH_U, CH_LU, CH_Y: act = ACT_NONE;
               default: act = ACT_BAD;
            endcase
         end else begin
            unique case (data_byte)
               CH_1: state_nxt.speed = SPEED_100;
               CH_2: state_nxt.speed = SPEED_120;
               CH_3: state_nxt.speed = SPEED_160;
               CH_U: begin
                  state_nxt.right_dir = DIR_FWD; state_nxt.right_duty = state_cur.speed;
                  state_nxt.left_dir  = DIR_FWD; state_nxt.left_duty  = state_cur.speed;
                  act = ACT_MOVE;
               end
               CH_N: begin
                  state_nxt.right_dir = DIR_REV; state_nxt.right_duty = state_cur.speed;
                  state_nxt.left_dir  = DIR_REV; state_nxt.left_duty  = state_cur.speed;
                  act = ACT_MOVE;
               end
               CH_L: begin
                  state_nxt.right_dir = DIR_FWD; state_nxt.right_duty = state_cur.speed;
                  state_nxt.left_dir  = DIR_REV; state_nxt.left_duty  = state_cur.speed;
                  act = ACT_MOVE;
               end
               CH_R: begin
                  state_nxt.right_dir = DIR_REV; state_nxt.right_duty = state_cur.speed;
                  state_nxt.left_dir  = DIR_FWD; state_nxt.left_duty  = state_cur.speed;
                  act = ACT_MOVE;
               end
               CH_X: begin
                  state_nxt.right_dir = DIR_OFF; state_nxt.right_duty = 8'd0;
                  state_nxt.left_dir  = DIR_OFF; state_nxt.left_duty  = 8'd0;
                  act = ACT_STOP;
               end
               CH_D: begin
                  state_nxt.right_dir = DIR_FWD; state_nxt.right_duty = state_cur.speed;
                  act = ACT_MOVE;
               end
               CH_E: begin
                  state_nxt.right_dir = DIR_REV; state_nxt.right_duty = state_cur.speed;
                  act = ACT_MOVE;
               end
               CH_C: begin
                  state_nxt.right_dir = DIR_OFF; state_nxt.right_duty = 8'd0;
                  act = ACT_STOP;
               end
               CH_I: begin
                  state_nxt.left_dir = DIR_FWD; state_nxt.left_duty = state_cur.speed;
                  act = ACT_MOVE;
               end
               CH_J: begin
                  state_nxt.left_dir = DIR_REV; state_nxt.left_duty = state_cur.speed;
                  act = ACT_MOVE;
               end
               CH_K: begin
                  state_nxt.left_dir = DIR_OFF; state_nxt.left_duty = 8'd0;
                  act = ACT_STOP;
               end
               default: act = ACT_BAD;
            endcase
         end
         status = (act == ACT_BAD) ? ST_BAD : ST_DONE;
         if (from_radio && act == ACT_MOVE) begin
            idle_nxt        = '0;
            state_nxt.armed = 1'b1;
         end else if (from_radio && act == ACT_STOP) begin
            idle_nxt        = '0;
            state_nxt.armed = 1'b0;
         end
      end else if (data_byte == CH_LF) begin
         if (line_open) begin
            if (from_radio) state_nxt.radio_open = 1'b0;
            else            state_nxt.wired_open = 1'b0;
            status = ST_LINE;
         end
      end else begin
         if (from_radio) state_nxt.radio_open = 1'b1;
         else            state_nxt.wired_open = 1'b1;
      end
   end

endmodule

[rtl/dcdw_out_fifo.sv]
// Two-entry result queue between the decoder and the response channel.
module dcdw_out_fifo #(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             not_empty,
   output logic             full,
   output logic [WIDTH-1:0] head_data
);

   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   assign not_empty = count_ff != 2'd0;
   assign full      = count_ff == 2'd2;
   assign head_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
